@@ rtl/sfpb_pkg.sv @@
// ============================================================================
// sfpb_pkg: servo frame packet builder shared definitions
// Microcode word layout, program step codes, command codes, register indexes,
// reset limit tables and the control store of the framer sequencer.
// ============================================================================
package sfpb_pkg;

    localparam int NUM_AXES_DEF = 6;
    localparam int NUM_AXES_MAX = 16;

    // Stream payload widths
    localparam int S_TDATA_W = 40;   // axis(3) + value_a(16) + value_b(16), padded to bytes
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Command codes (carried on s_tuser)
    localparam logic [1:0] CMD_SET_POS = 2'd0;
    localparam logic [1:0] CMD_SET_LIM = 2'd1;
    localparam logic [1:0] CMD_SEND    = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INSTR     = 1'b1;

    localparam logic [15:0] MOVE_TIME_RST = 16'd5000;
    localparam logic [7:0]  INSTR_RST     = 8'd0;

    // Packet constants
    localparam logic [7:0] HDR_BYTE0   = 8'd255;
    localparam logic [7:0] HDR_BYTE1   = 8'd253;
    localparam logic [7:0] SUM_SEED    = 8'(508 % 256);
    localparam logic [7:0] CKS_BASE    = 8'd254;

    // Program steps
    typedef logic [3:0] step_t;
    localparam step_t ST_IDLE   = 4'd0;
    localparam step_t ST_SETPOS = 4'd1;
    localparam step_t ST_SETLIM = 4'd2;
    localparam step_t ST_HDR0   = 4'd3;
    localparam step_t ST_HDR1   = 4'd4;
    localparam step_t ST_LEN    = 4'd5;
    localparam step_t ST_INSTR  = 4'd6;
    localparam step_t ST_TLO    = 4'd7;
    localparam step_t ST_THI    = 4'd8;
    localparam step_t ST_PLO    = 4'd9;
    localparam step_t ST_PHI    = 4'd10;
    localparam step_t ST_CKS    = 4'd11;

    typedef enum logic [3:0] {
        BS_HDR0  = 4'd0,
        BS_HDR1  = 4'd1,
        BS_LEN   = 4'd2,
        BS_INSTR = 4'd3,
        BS_TLO   = 4'd4,
        BS_THI   = 4'd5,
        BS_PLO   = 4'd6,
        BS_PHI   = 4'd7,
        BS_CKS   = 4'd8
    } byte_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_INIT = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD = 2'd0,
        PTR_CLR  = 2'd1,
        PTR_INC  = 2'd2
    } ptr_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_DISPATCH = 2'd1,
        JMP_LOOP     = 2'd2,
        JMP_ALWAYS   = 2'd3
    } jmp_t;

    typedef struct packed {
        logic      in_rdy;
        logic      emit;
        logic      last;
        byte_sel_t bsel;
        acc_op_t   acc_op;
        ptr_op_t   ptr_op;
        logic      wr_pos;
        logic      wr_lim;
        jmp_t      jmp;
        step_t     target;
    } cw_t;

    // Sequencer to datapath control
    typedef struct packed {
        cw_t  cw;
        logic adv;
    } ctl_t;

    // Control store
    function automatic cw_t ucode(input step_t s);
        cw_t w;
        w = '{in_rdy: 1'b0, emit: 1'b0, last: 1'b0, bsel: BS_HDR0, acc_op: ACC_HOLD,
              ptr_op: PTR_HOLD, wr_pos: 1'b0, wr_lim: 1'b0, jmp: JMP_NEXT,
              target: ST_IDLE};
        case (s)
            ST_IDLE: begin
                w.in_rdy = 1'b1;
                w.jmp    = JMP_DISPATCH;
            end
            ST_SETPOS: begin
                w.wr_pos = 1'b1;
                w.jmp    = JMP_ALWAYS;
            end
            ST_SETLIM: begin
                w.wr_lim = 1'b1;
                w.jmp    = JMP_ALWAYS;
            end
            ST_HDR0: begin
                w.emit   = 1'b1;
                w.acc_op = ACC_INIT;
                w.ptr_op = PTR_CLR;
            end
            ST_HDR1: begin
                w.emit = 1'b1;
                w.bsel = BS_HDR1;
            end
            ST_LEN: begin
                w.emit   = 1'b1;
                w.bsel   = BS_LEN;
                w.acc_op = ACC_ADD;
            end
            ST_INSTR: begin
                w.emit   = 1'b1;
                w.bsel   = BS_INSTR;
                w.acc_op = ACC_ADD;
            end
            ST_TLO: begin
                w.emit   = 1'b1;
                w.bsel   = BS_TLO;
                w.acc_op = ACC_ADD;
            end
            ST_THI: begin
                w.emit   = 1'b1;
                w.bsel   = BS_THI;
                w.acc_op = ACC_ADD;
            end
            ST_PLO: begin
                w.emit   = 1'b1;
                w.bsel   = BS_PLO;
                w.acc_op = ACC_ADD;
            end
            ST_PHI: begin
                w.emit   = 1'b1;
                w.bsel   = BS_PHI;
                w.acc_op = ACC_ADD;
                w.ptr_op = PTR_INC;
                w.jmp    = JMP_LOOP;
                w.target = ST_PLO;
            end
            ST_CKS: begin
                w.emit = 1'b1;
                w.last = 1'b1;
                w.bsel = BS_CKS;
                w.jmp  = JMP_ALWAYS;
            end
            default: begin
                w.jmp = JMP_ALWAYS;
            end
        endcase
        return w;
    endfunction

    // Reset limits; axes past the sixth get the full range
    function automatic logic [15:0] reset_min(input int i);
        logic [15:0] v;
        case (i)
            0:       v = 16'd700;
            1:       v = 16'd2000;
            2:       v = 16'd500;
            3:       v = 16'd500;
            4:       v = 16'd200;
            5:       v = 16'd300;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] reset_max(input int i);
        logic [15:0] v;
        case (i)
            0:       v = 16'd2800;
            1:       v = 16'd4100;
            2:       v = 16'd2600;
            3:       v = 16'd2600;
            4:       v = 16'd820;
            5:       v = 16'd700;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] reset_pos(input int i);
        logic [16:0] s;
        s = {1'b0, reset_min(i)} + {1'b0, reset_max(i)};
        return s[16:1];
    endfunction

endpackage

@@ rtl/servo_frame_packet_builder_top.sv @@
// ============================================================================
// servo_frame_packet_builder_top: servo packet framer
// Keeps per-axis limits and positions and frames them into a servo packet.
// ============================================================================
// Usage:
//   Slave stream carries commands: s_tuser is the command (set position,
//   set limits, send packet), s_tdata holds axis and the two values.
//   A set command is accepted at idle and then runs one write step.
//   A send command is accepted at idle and then runs one microcode step per
//   packet byte. The first byte is loaded into the output register by the
//   HDR0 step that follows acceptance; while the receiver does not stall,
//   one byte follows per cycle.
//   Master stream carries one packet byte per transaction in m_tdata, with
//   m_tlast high on the checksum byte.
//   When the receiver stalls, the byte sequencer holds on its current step;
//   the output register keeps the pending byte. A new command is taken as
//   soon as the sequencer is back at idle, even if the checksum byte is
//   still waiting to be taken.
//   Reset (aresetn low, synchronous) restores the limit tables, centers each
//   position between its limits, sets move_time to 5000 and the instruction
//   code to 0, and empties the output register.
//   Write move_time and instruction_code through cfg_* only while idle.
// ============================================================================
module servo_frame_packet_builder_top #(
    parameter int NUM_AXES = sfpb_pkg::NUM_AXES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfpb_pkg::S_TDATA_W-1:0]   s_tdata,  // axis[2:0], value_a[18:3], value_b[34:19]
    input  logic [sfpb_pkg::S_TUSER_W-1:0]   s_tuser,  // command[1:0]
    // packet byte stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sfpb_pkg::M_TDATA_W-1:0]   m_tdata,  // packet_byte[7:0]
    output logic                             m_tlast,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [sfpb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sfpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sfpb_pkg::*;

    ctl_t        ctl;
    logic        s_fire;
    logic        out_free;
    logic        out_load;
    logic        ptr_last;
    logic [7:0]  pkt_byte;

    logic [15:0] move_time_reg;
    logic [7:0]  instr_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;

    // Only the idle step of the program takes commands
    assign s_tready = ctl.cw.in_rdy;
    assign s_fire   = s_tvalid && s_tready;

    // Output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ctl.adv && ctl.cw.emit;

    sfpb_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .s_cmd    (s_tuser),
        .out_free (out_free),
        .ptr_last (ptr_last),
        .ctl      (ctl)
    );

    sfpb_dp #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .s_fire           (s_fire),
        .s_axis           (s_tdata[2:0]),
        .s_value_a        (s_tdata[18:3]),
        .s_value_b        (s_tdata[34:19]),
        .move_time        (move_time_reg),
        .instruction_code (instr_reg),
        .pkt_byte         (pkt_byte),
        .ptr_last         (ptr_last)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_time_reg <= MOVE_TIME_RST;
            instr_reg     <= INSTR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MOVE_TIME: move_time_reg <= cfg_wdata;
                REG_INSTR:     instr_reg     <= cfg_wdata[7:0];
                default:       instr_reg     <= instr_reg;
            endcase
        end
    end

    // Output register: load a byte, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= pkt_byte;
            m_tlast_reg <= ctl.cw.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_no_cmd_mid_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> !m_tvalid_reg || m_tlast_reg)
        else $error("command accepted in the middle of a packet");
    a_header_after_send: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && ctl.cw.bsel == BS_HDR0 |=> m_tvalid_reg && m_tdata_reg == HDR_BYTE0
        && !m_tlast_reg)
        else $error("send did not start with the header byte");
    a_no_load_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !out_load)
        else $error("output register overwritten while stalled");
`endif

endmodule

@@ rtl/sfpb_seq.sv @@
// ============================================================================
// sfpb_seq: microprogram sequencer
// Step counter over the control store, with command dispatch and axis loop.
// ============================================================================
module sfpb_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_fire,
    input  logic [1:0]            s_cmd,
    input  logic                  out_free,
    input  logic                  ptr_last,
    output sfpb_pkg::ctl_t        ctl
);
    import sfpb_pkg::*;

    step_t step_reg;
    step_t step_next;
    cw_t   cw;
    logic  adv;

    assign cw  = ucode(step_reg);
    // Emitting steps wait for room in the output register
    assign adv = cw.emit ? out_free : 1'b1;
    assign ctl = '{cw: cw, adv: adv};

    always_comb begin
        step_next = step_reg;
        case (cw.jmp)
            JMP_NEXT:   step_next = step_reg + step_t'(1);
            JMP_ALWAYS: step_next = cw.target;
            JMP_LOOP:   step_next = ptr_last ? step_reg + step_t'(1) : cw.target;
            JMP_DISPATCH: begin
                if (s_fire) begin
                    case (s_cmd)
                        CMD_SET_POS: step_next = ST_SETPOS;
                        CMD_SET_LIM: step_next = ST_SETLIM;
                        CMD_SEND:    step_next = ST_HDR0;
                        default:     step_next = ST_IDLE;
                    endcase
                end
            end
            default:    step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else if (adv) begin
            step_reg <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= ST_CKS)
        else $error("sequencer left the program");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.emit && !out_free |=> step_reg == $past(step_reg))
        else $error("emitting step advanced while output was full");
    a_fire_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> step_reg == ST_IDLE)
        else $error("input accepted outside idle step");
`endif

endmodule

@@ rtl/sfpb_dp.sv @@
// ============================================================================
// sfpb_dp: framer datapath
// Axis limit/position registers, clamp, packet byte select and checksum.
// ============================================================================
module sfpb_dp #(
    parameter int NUM_AXES = sfpb_pkg::NUM_AXES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sfpb_pkg::ctl_t        ctl,
    input  logic                  s_fire,
    input  logic [2:0]            s_axis,
    input  logic [15:0]           s_value_a,
    input  logic [15:0]           s_value_b,
    input  logic [15:0]           move_time,
    input  logic [7:0]            instruction_code,
    output logic [7:0]            pkt_byte,
    output logic                  ptr_last
);
    import sfpb_pkg::*;

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [7:0] LEN_BYTE = 8'((2 * NUM_AXES + 4) % 256);

    logic [15:0]    pos_reg  [NUM_AXES];
    logic [15:0]    min_reg  [NUM_AXES];
    logic [15:0]    max_reg  [NUM_AXES];

    logic [2:0]     axis_reg;
    logic [15:0]    va_reg;
    logic [15:0]    vb_reg;
    logic [AXW-1:0] ptr_reg;
    logic [7:0]     acc_reg;

    logic [AXW+2:0] axis_ext;
    logic [AXW-1:0] axis_idx;
    logic           axis_ok;
    logic [15:0]    lo_clamp;
    logic [15:0]    clamped;
    logic [15:0]    cur_pos;

    assign axis_ext = (AXW + 3)'(axis_reg);
    assign axis_idx = axis_ext[AXW-1:0];
    assign axis_ok  = 32'(axis_reg) < NUM_AXES;
    assign ptr_last = ptr_reg == AXW'(NUM_AXES - 1);
    assign cur_pos  = pos_reg[ptr_reg];

    // Raise to min first, then lower to max: inverted limits land on max
    assign lo_clamp = (va_reg < min_reg[axis_idx]) ? min_reg[axis_idx] : va_reg;
    assign clamped  = (lo_clamp > max_reg[axis_idx]) ? max_reg[axis_idx] : lo_clamp;

    always_comb begin
        case (ctl.cw.bsel)
            BS_HDR0:  pkt_byte = HDR_BYTE0;
            BS_HDR1:  pkt_byte = HDR_BYTE1;
            BS_LEN:   pkt_byte = LEN_BYTE;
            BS_INSTR: pkt_byte = instruction_code;
            BS_TLO:   pkt_byte = move_time[7:0];
            BS_THI:   pkt_byte = move_time[15:8];
            BS_PLO:   pkt_byte = cur_pos[7:0];
            BS_PHI:   pkt_byte = cur_pos[15:8];
            BS_CKS:   pkt_byte = CKS_BASE - acc_reg;
            default:  pkt_byte = HDR_BYTE0;
        endcase
    end

    // Capture the command operands
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            axis_reg <= s_axis;
            va_reg   <= s_value_a;
            vb_reg   <= s_value_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                pos_reg[i] <= reset_pos(i);
                min_reg[i] <= reset_min(i);
                max_reg[i] <= reset_max(i);
            end
        end else if (ctl.adv && axis_ok) begin
            if (ctl.cw.wr_pos) begin
                pos_reg[axis_idx] <= clamped;
            end
            if (ctl.cw.wr_lim) begin
                min_reg[axis_idx] <= va_reg;
                max_reg[axis_idx] <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            acc_reg <= '0;
        end else if (ctl.adv) begin
            case (ctl.cw.ptr_op)
                PTR_CLR: ptr_reg <= '0;
                PTR_INC: ptr_reg <= ptr_last ? '0 : ptr_reg + AXW'(1);
                default: ptr_reg <= ptr_reg;
            endcase
            case (ctl.cw.acc_op)
                ACC_INIT: acc_reg <= SUM_SEED;
                ACC_ADD:  acc_reg <= acc_reg + pkt_byte;
                default:  acc_reg <= acc_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < NUM_AXES)
        else $error("axis pointer out of range");
    a_seed_first: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.adv && ctl.cw.acc_op == ACC_INIT |=> acc_reg == SUM_SEED)
        else $error("checksum not seeded");
    a_ptr_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.adv && ctl.cw.bsel == BS_HDR0 && ctl.cw.emit |=> ptr_reg == '0)
        else $error("axis pointer not cleared at packet start");
`endif

endmodule
